// ===== hdl/satq_pkg.sv =====
// ----------------------------------------------------------------------------
// satq_pkg
// Shared constants, codes and types of the segment accumulating transmit
// queue.
// ----------------------------------------------------------------------------
package satq_pkg;

   localparam int NUM_SEGMENTS  = 16;
   localparam int SEGMENT_BYTES = 1024;
   localparam int MAX_PACKET    = 256;
   localparam int ALIGN_BYTES   = 4;
   localparam int HEADER_BYTES  = 4;

   localparam int IDX_W     = $clog2(NUM_SEGMENTS);
   localparam int CNT_W     = $clog2(NUM_SEGMENTS + 1);
   localparam int BYTES_W   = $clog2(SEGMENT_BYTES + 1);
   localparam int COUNT_W   = 8;
   localparam int COUNT_MAX = 255;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 3;
   localparam int SIZE_W    = 16;
   localparam int HANDLE_W  = 4;
   localparam int LOST_W    = 32;
   localparam int STAMP_W   = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACQUIRE = 3'd0,
      CMD_COMMIT  = 3'd1,
      CMD_POP     = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_BAD_SIZE      = 3'd1,
      ST_OVERFLOW      = 3'd2,
      ST_NOTHING_READY = 3'd3,
      ST_RELEASE_EMPTY = 3'd4
   } status_type;

   typedef struct packed {
      logic                  load;
      logic                  update;
      logic [CMD_W-1:0]      op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [BYTES_W-1:0]    bytes;
      logic [COUNT_W-1:0]    uncommitted;
      logic [COUNT_W-1:0]    messages;
   } seg_entry_type;

endpackage

// ===== hdl/satq_ctrl.sv =====
// ----------------------------------------------------------------------------
// satq_ctrl
// Command controller: accepts a command, sequences the table read and the
// update cycle, and marks the result.
// ----------------------------------------------------------------------------
module satq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [satq_pkg::CMD_W-1:0]      req_command,
   output logic                            busy,
   output logic                            rsp_strobe,
   output satq_pkg::ctl_cmd_type           ctl
);
   import satq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   op_ff;
   logic               strobe_ff;
   logic               accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = accept ? S_UPDATE : S_IDLE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_command;
      end
   end

   assign ctl.load   = accept;
   assign ctl.update = (state_ff == S_UPDATE);
   assign ctl.op     = op_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== hdl/satq_dpath.sv =====
// ----------------------------------------------------------------------------
// satq_dpath
// Datapath: ring indexes, per-segment table, lost and stamp counters, and the
// result registers.
// ----------------------------------------------------------------------------
module satq_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  satq_pkg::ctl_cmd_type             ctl,
   input  logic [satq_pkg::CMD_W-1:0]        req_command,
   input  logic [satq_pkg::SIZE_W-1:0]       req_packet_size,
   input  logic [satq_pkg::HANDLE_W-1:0]     req_segment_handle,
   input  logic                              req_flush,
   output logic [satq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [satq_pkg::HANDLE_W-1:0]     rsp_segment_index,
   output logic [satq_pkg::BYTES_W-1:0]      rsp_byte_offset,
   output logic [satq_pkg::BYTES_W-1:0]      rsp_byte_length,
   output logic [satq_pkg::LOST_W-1:0]       rsp_lost_packets,
   output logic [satq_pkg::STAMP_W-1:0]      rsp_counter_base,
   output logic [satq_pkg::COUNT_W-1:0]      rsp_message_count,
   output logic [satq_pkg::CNT_W-1:0]        rsp_fill_level
);
   import satq_pkg::*;

   localparam int SUM_W = SIZE_W + 2;

   // ring state
   logic [IDX_W-1:0]    read_index_ff, read_index_in;
   logic [CNT_W-1:0]    fill_count_ff, fill_count_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]    cur_seg_ff, cur_seg_in;
   logic [BYTES_W-1:0]  cur_bytes_ff, cur_bytes_in;
   logic [LOST_W-1:0]   lost_ff, lost_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;

   // segment table
   seg_entry_type       seg_mem [NUM_SEGMENTS];
   logic                seg_valid_ff [NUM_SEGMENTS];
   seg_entry_type       rd_ff;
   logic                rd_valid_ff;
   seg_entry_type       rd_entry;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   seg_entry_type       mem_wdata;
   logic                clr_en;

   // values decided at accept
   logic [SUM_W-1:0]    round_sum, padded_full, msg_full, fit_sum;
   logic [IDX_W:0]      pos_sum;
   logic [IDX_W-1:0]    open_pos, raddr;
   logic                bad_size, need_new, ring_full, handle_ok;

   logic [BYTES_W-1:0]  padded_ff, msg_ff;
   logic                bad_ff, need_new_ff, full_ff, handle_ok_ff, flush_ff;
   logic [IDX_W-1:0]    pos_ff, raddr_ff;

   // result next values
   logic [STATUS_W-1:0] status_in;
   logic [HANDLE_W-1:0] sidx_in;
   logic [BYTES_W-1:0]  offs_in, blen_in;
   logic [LOST_W-1:0]   lostrep_in;
   logic [STAMP_W-1:0]  cbase_in;
   logic [COUNT_W-1:0]  mcount_in;
   logic [CNT_W-1:0]    level_in;

   logic                pop_open;
   logic [CNT_W-1:0]    pop_fill;
   seg_entry_type       base;
   logic [IDX_W-1:0]    acq_seg;

   assign round_sum   = SUM_W'(req_packet_size) + SUM_W'(ALIGN_BYTES - 1);
   assign padded_full = round_sum - SUM_W'(round_sum % ALIGN_BYTES);
   assign msg_full    = padded_full + SUM_W'(HEADER_BYTES);
   assign bad_size    = (req_packet_size == '0) || (req_packet_size > MAX_PACKET)
                        || (msg_full > SEGMENT_BYTES);
   assign fit_sum     = SUM_W'(cur_bytes_ff) + msg_full;
   assign need_new    = !cur_valid_ff || (fit_sum > SEGMENT_BYTES);
   assign ring_full   = (fill_count_ff >= NUM_SEGMENTS);
   assign pos_sum     = (IDX_W+1)'(read_index_ff) + (IDX_W+1)'(fill_count_ff);
   assign open_pos    = (pos_sum >= NUM_SEGMENTS) ? IDX_W'(pos_sum - NUM_SEGMENTS)
                                                  : IDX_W'(pos_sum);
   assign handle_ok   = (req_segment_handle < NUM_SEGMENTS);

   always_comb begin
      case (cmd_type'(req_command))
         CMD_COMMIT: raddr = IDX_W'(req_segment_handle);
         CMD_POP:    raddr = read_index_ff;
         default:    raddr = cur_seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         padded_ff    <= BYTES_W'(padded_full);
         msg_ff       <= BYTES_W'(msg_full);
         bad_ff       <= bad_size;
         need_new_ff  <= need_new;
         full_ff      <= ring_full;
         handle_ok_ff <= handle_ok;
         flush_ff     <= req_flush;
         pos_ff       <= open_pos;
         raddr_ff     <= raddr;
         rd_ff        <= seg_mem[raddr];
         rd_valid_ff  <= seg_valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[mem_waddr] <= mem_wdata;
      end
   end

   // an entry that is not valid reads as zero; opening a segment on a flush drops its bit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (mem_we) begin
            seg_valid_ff[mem_waddr] <= 1'b1;
         end
         if (clr_en) begin
            seg_valid_ff[pos_ff] <= 1'b0;
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_ff : '0;
   assign base     = need_new_ff ? '0 : rd_entry;
   assign acq_seg  = need_new_ff ? pos_ff : cur_seg_ff;
   assign pop_open = (fill_count_ff == CNT_W'(1)) && (rd_entry.bytes != '0) && flush_ff;
   assign pop_fill = fill_count_ff + CNT_W'(pop_open);

   always_comb begin
      read_index_in = read_index_ff;
      fill_count_in = fill_count_ff;
      cur_valid_in  = cur_valid_ff;
      cur_seg_in    = cur_seg_ff;
      cur_bytes_in  = cur_bytes_ff;
      lost_in       = lost_ff;
      stamp_in      = stamp_ff;
      mem_we        = 1'b0;
      mem_waddr     = raddr_ff;
      mem_wdata     = rd_entry;
      clr_en        = 1'b0;
      status_in     = ST_OK;
      sidx_in       = '0;
      offs_in       = '0;
      blen_in       = '0;
      lostrep_in    = '0;
      cbase_in      = '0;
      mcount_in     = '0;
      case (cmd_type'(ctl.op))
         CMD_ACQUIRE: begin
            if (bad_ff) begin
               status_in = ST_BAD_SIZE;
            end else if (need_new_ff && full_ff) begin
               cur_valid_in = 1'b0;
               lost_in      = lost_ff + LOST_W'(1);
               status_in    = ST_OVERFLOW;
            end else begin
               mem_we                = 1'b1;
               mem_waddr             = acq_seg;
               mem_wdata.bytes       = base.bytes + msg_ff;
               mem_wdata.uncommitted = (base.uncommitted == COUNT_W'(COUNT_MAX)) ?
                                       base.uncommitted : base.uncommitted + COUNT_W'(1);
               mem_wdata.messages    = (base.messages == COUNT_W'(COUNT_MAX)) ?
                                       base.messages : base.messages + COUNT_W'(1);
               cur_seg_in            = acq_seg;
               cur_valid_in          = 1'b1;
               cur_bytes_in          = base.bytes + msg_ff;
               if (need_new_ff) begin
                  fill_count_in = fill_count_ff + CNT_W'(1);
               end
               sidx_in = HANDLE_W'(acq_seg);
               offs_in = base.bytes;
               blen_in = padded_ff;
            end
         end
         CMD_COMMIT: begin
            if (handle_ok_ff && (rd_entry.uncommitted != '0)) begin
               mem_we                = 1'b1;
               mem_wdata.uncommitted = rd_entry.uncommitted - COUNT_W'(1);
            end
            if (flush_ff && cur_valid_ff && (cur_bytes_ff != '0)) begin
               if (full_ff) begin
                  cur_valid_in = 1'b0;
               end else begin
                  clr_en        = 1'b1;
                  cur_seg_in    = pos_ff;
                  cur_valid_in  = 1'b1;
                  cur_bytes_in  = '0;
                  fill_count_in = fill_count_ff + CNT_W'(1);
               end
            end
         end
         CMD_POP: begin
            lostrep_in = lost_ff;
            lost_in    = '0;
            if (pop_open) begin
               clr_en        = 1'b1;
               cur_seg_in    = pos_ff;
               cur_valid_in  = 1'b1;
               cur_bytes_in  = '0;
               fill_count_in = pop_fill;
            end
            if ((pop_fill > CNT_W'(1)) && (rd_entry.uncommitted == '0)
                && (rd_entry.bytes != '0)) begin
               sidx_in   = HANDLE_W'(read_index_ff);
               blen_in   = rd_entry.bytes;
               cbase_in  = stamp_ff;
               mcount_in = rd_entry.messages;
               stamp_in  = stamp_ff + STAMP_W'(rd_entry.messages);
            end else begin
               status_in = ST_NOTHING_READY;
            end
         end
         CMD_RELEASE: begin
            if (fill_count_ff == '0) begin
               status_in = ST_RELEASE_EMPTY;
            end else begin
               if (cur_valid_ff && (cur_seg_ff == read_index_ff)) begin
                  cur_valid_in = 1'b0;
               end
               read_index_in = (read_index_ff == IDX_W'(NUM_SEGMENTS - 1)) ?
                               '0 : read_index_ff + IDX_W'(1);
               fill_count_in = fill_count_ff - CNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            read_index_in = '0;
            fill_count_in = '0;
            cur_valid_in  = 1'b0;
         end
         default: begin
         end
      endcase
      if (!ctl.update) begin
         mem_we = 1'b0;
         clr_en = 1'b0;
      end
   end

   always_comb begin
      if (fill_count_in > CNT_W'(1)) begin
         level_in = fill_count_in;
      end else if ((fill_count_in == CNT_W'(1)) && cur_valid_in && (cur_bytes_in != '0)) begin
         level_in = fill_count_in;
      end else begin
         level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff <= '0;
         fill_count_ff <= CNT_W'(1);
         cur_valid_ff  <= 1'b1;
         cur_seg_ff    <= '0;
         cur_bytes_ff  <= '0;
         lost_ff       <= '0;
         stamp_ff      <= '0;
      end else if (ctl.update) begin
         read_index_ff <= read_index_in;
         fill_count_ff <= fill_count_in;
         cur_valid_ff  <= cur_valid_in;
         cur_seg_ff    <= cur_seg_in;
         cur_bytes_ff  <= cur_bytes_in;
         lost_ff       <= lost_in;
         stamp_ff      <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         rsp_status        <= status_in;
         rsp_segment_index <= sidx_in;
         rsp_byte_offset   <= offs_in;
         rsp_byte_length   <= blen_in;
         rsp_lost_packets  <= lostrep_in;
         rsp_counter_base  <= cbase_in;
         rsp_message_count <= mcount_in;
         rsp_fill_level    <= level_in;
      end
   end

endmodule

// ===== hdl/segment_accumulating_tx_queue.sv =====
// ----------------------------------------------------------------------------
// segment_accumulating_tx_queue
// Ring of transmit segments that collect messages: acquire, commit, pop,
// release and clear commands, one result per command.
// ----------------------------------------------------------------------------
// A command reads, in its accept cycle, the segment table entry that it
// addresses, and the next cycle does the read-modify-write of that entry
// and the ring state. The result appears on the rsp_ ports in the cycle after
// that, flagged by rsp_strobe, and the receiver cannot stall it; busy drops
// in that same cycle, so a new command can be accepted while the result is
// on the ports, and not before. No clearing pass follows reset.
module segment_accumulating_tx_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [satq_pkg::CMD_W-1:0]        req_command,
   input  logic [satq_pkg::SIZE_W-1:0]       req_packet_size,
   input  logic [satq_pkg::HANDLE_W-1:0]     req_segment_handle,
   input  logic                              req_flush,
   output logic                              rsp_strobe,
   output logic [satq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [satq_pkg::HANDLE_W-1:0]     rsp_segment_index,
   output logic [satq_pkg::BYTES_W-1:0]      rsp_byte_offset,
   output logic [satq_pkg::BYTES_W-1:0]      rsp_byte_length,
   output logic [satq_pkg::LOST_W-1:0]       rsp_lost_packets,
   output logic [satq_pkg::STAMP_W-1:0]      rsp_counter_base,
   output logic [satq_pkg::COUNT_W-1:0]      rsp_message_count,
   output logic [satq_pkg::CNT_W-1:0]        rsp_fill_level
);
   import satq_pkg::*;

   ctl_cmd_type ctl;

   satq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .ctl         (ctl)
   );

   satq_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_command        (req_command),
      .req_packet_size    (req_packet_size),
      .req_segment_handle (req_segment_handle),
      .req_flush          (req_flush),
      .rsp_status         (rsp_status),
      .rsp_segment_index  (rsp_segment_index),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_lost_packets   (rsp_lost_packets),
      .rsp_counter_base   (rsp_counter_base),
      .rsp_message_count  (rsp_message_count),
      .rsp_fill_level     (rsp_fill_level)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted command gave no result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result flagged while a command is in progress");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_OVERFLOW)) |-> (rsp_fill_level == NUM_SEGMENTS))
      else $error("overflow reported with room in the ring");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_fill_level <= NUM_SEGMENTS))
      else $error("fill level beyond ring size");

endmodule

// ===== tb/sv/segment_accumulating_tx_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_accumulating_tx_queue_tb
// Self-checking bench for the transmit segment ring: a directed run through
// bad sizes, lone-segment flush, repeated pop, release of the current
// segment, release on an empty ring, clear and spare command codes, then
// fill, drain and mixed traffic of all command codes, spare ones included.
// A scoreboard class tracks the ring and checks every response.
// ----------------------------------------------------------------------------
module segment_accumulating_tx_queue_tb;
   import satq_pkg::*;

   localparam int FIRST_SPARE_CMD = int'(CMD_CLEAR) + 1;
   localparam int LAST_SPARE_CMD  = (1 << CMD_W) - 1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] segment_index;
      logic [BYTES_W-1:0]  byte_offset;
      logic [BYTES_W-1:0]  byte_length;
      logic [LOST_W-1:0]   lost_packets;
      logic [STAMP_W-1:0]  counter_base;
      logic [COUNT_W-1:0]  message_count;
      logic [CNT_W-1:0]    fill_level;
   } queue_response_type;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   class ring_scoreboard;
      logic [IDX_W-1:0]   read_index;
      logic [CNT_W-1:0]   fill_count;
      logic               current_valid;
      logic [IDX_W-1:0]   current_segment;
      logic [BYTES_W-1:0] seg_bytes [NUM_SEGMENTS];
      logic [COUNT_W-1:0] seg_uncommitted [NUM_SEGMENTS];
      logic [COUNT_W-1:0] seg_messages [NUM_SEGMENTS];
      logic [LOST_W-1:0]  lost_total;
      logic [STAMP_W-1:0] message_counter;
      queue_response_type expected_responses [$];
      int                 error_count;

      function new();
         read_index      = '0;
         fill_count      = 1;
         current_valid   = 1'b1;
         current_segment = '0;
         lost_total      = '0;
         message_counter = '0;
         error_count     = 0;
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_bytes[i]       = '0;
            seg_uncommitted[i] = '0;
            seg_messages[i]    = '0;
         end
      endfunction

      function void open_segment();
         int pos;
         if (fill_count >= NUM_SEGMENTS) begin
            current_valid = 1'b0;
            return;
         end
         pos = int'(read_index) + int'(fill_count);
         if (pos >= NUM_SEGMENTS)
            pos -= NUM_SEGMENTS;
         seg_bytes[pos]       = '0;
         seg_uncommitted[pos] = '0;
         seg_messages[pos]    = '0;
         current_segment      = IDX_W'(pos);
         current_valid        = 1'b1;
         fill_count++;
      endfunction

      function logic [CNT_W-1:0] pending_segments();
         if (fill_count > 1)
            return fill_count;
         if (fill_count == 1 && current_valid && seg_bytes[current_segment] > 0)
            return fill_count;
         return '0;
      endfunction

      function queue_response_type ring_step(input logic [CMD_W-1:0] cmd,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [HANDLE_W-1:0] handle,
                                             input logic flush);
         queue_response_type r;
         int                 padded;
         int                 msg;
         logic [IDX_W-1:0]   b;
         logic               ready;
         r = '0;
         case (cmd)
            CMD_ACQUIRE: begin
               padded = ((int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
               msg    = padded + HEADER_BYTES;
               if (size == 0 || size > MAX_PACKET || msg > SEGMENT_BYTES) begin
                  r.status = ST_BAD_SIZE;
               end else begin
                  if (!current_valid || int'(seg_bytes[current_segment]) + msg > SEGMENT_BYTES)
                     open_segment();
                  if (current_valid) begin
                     r.byte_offset = seg_bytes[current_segment];
                     seg_bytes[current_segment] += BYTES_W'(msg);
                     if (seg_uncommitted[current_segment] < COUNT_MAX)
                        seg_uncommitted[current_segment]++;
                     if (seg_messages[current_segment] < COUNT_MAX)
                        seg_messages[current_segment]++;
                     r.segment_index = current_segment;
                     r.byte_length   = BYTES_W'(padded);
                  end else begin
                     lost_total++;
                     r.status = ST_OVERFLOW;
                  end
               end
            end
            CMD_COMMIT: begin
               if (seg_uncommitted[handle] > 0)
                  seg_uncommitted[handle]--;
               if (flush && current_valid && seg_bytes[current_segment] > 0)
                  open_segment();
            end
            CMD_POP: begin
               b              = read_index;
               ready          = 1'b0;
               r.lost_packets = lost_total;
               lost_total     = '0;
               if (fill_count >= 1) begin
                  if (fill_count == 1 && seg_bytes[b] > 0 && flush)
                     open_segment();
                  ready = fill_count > 1 && seg_uncommitted[b] == 0 && seg_bytes[b] > 0;
               end
               if (ready) begin
                  r.segment_index  = b;
                  r.byte_length    = seg_bytes[b];
                  r.counter_base   = message_counter;
                  r.message_count  = seg_messages[b];
                  message_counter += STAMP_W'(seg_messages[b]);
               end else begin
                  r.status = ST_NOTHING_READY;
               end
            end
            CMD_RELEASE: begin
               if (fill_count == 0) begin
                  r.status = ST_RELEASE_EMPTY;
               end else begin
                  if (current_valid && current_segment == read_index)
                     current_valid = 1'b0;
                  read_index++;
                  fill_count--;
               end
            end
            CMD_CLEAR: begin
               read_index    = '0;
               fill_count    = '0;
               current_valid = 1'b0;
            end
            default: ;
         endcase
         r.fill_level = pending_segments();
         return r;
      endfunction

      function queue_response_type note_transfer(input logic [CMD_W-1:0] cmd,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [HANDLE_W-1:0] handle,
                                                 input logic flush);
         queue_response_type r;
         r = ring_step(cmd, size, handle, flush);
         expected_responses.push_back(r);
         return r;
      endfunction

      function void compare_field(input string name, input longint unsigned want,
                                  input longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(input queue_response_type got);
         queue_response_type want;
         if (expected_responses.size() == 0) begin
            $error("response with nothing outstanding");
            error_count++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("segment_index", want.segment_index, got.segment_index);
         compare_field("byte_offset", want.byte_offset, got.byte_offset);
         compare_field("byte_length", want.byte_length, got.byte_length);
         compare_field("lost_packets", want.lost_packets, got.lost_packets);
         compare_field("counter_base", want.counter_base, got.counter_base);
         compare_field("message_count", want.message_count, got.message_count);
         compare_field("fill_level", want.fill_level, got.fill_level);
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = '0;
   logic [SIZE_W-1:0]     req_packet_size = '0;
   logic [HANDLE_W-1:0]   req_segment_handle = '0;
   logic                  req_flush = 1'b0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [HANDLE_W-1:0]   rsp_segment_index;
   logic [BYTES_W-1:0]    rsp_byte_offset;
   logic [BYTES_W-1:0]    rsp_byte_length;
   logic [LOST_W-1:0]     rsp_lost_packets;
   logic [STAMP_W-1:0]    rsp_counter_base;
   logic [COUNT_W-1:0]    rsp_message_count;
   logic [CNT_W-1:0]      rsp_fill_level;

   ring_scoreboard        sb = new();
   logic [HANDLE_W-1:0]   open_handles [$];
   logic                  sender_idles = 1'b1;

   segment_accumulating_tx_queue i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_packet_size    (req_packet_size),
      .req_segment_handle (req_segment_handle),
      .req_flush          (req_flush),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_segment_index  (rsp_segment_index),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_byte_length    (rsp_byte_length),
      .rsp_lost_packets   (rsp_lost_packets),
      .rsp_counter_base   (rsp_counter_base),
      .rsp_message_count  (rsp_message_count),
      .rsp_fill_level     (rsp_fill_level)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(queue_response_type'{rsp_status, rsp_segment_index,
                                              rsp_byte_offset, rsp_byte_length,
                                              rsp_lost_packets, rsp_counter_base,
                                              rsp_message_count, rsp_fill_level});
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                            input logic [HANDLE_W-1:0] handle, input logic flush);
      queue_response_type r;
      if (sender_idles && $urandom_range(99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start              <= 1'b1;
      req_command        <= cmd;
      req_packet_size    <= size;
      req_segment_handle <= handle;
      req_flush          <= flush;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = sb.note_transfer(cmd, size, handle, flush);
      if (cmd == CMD_ACQUIRE && r.status == ST_OK)
         open_handles.push_back(r.segment_index);
      if (cmd == CMD_CLEAR)
         open_handles.delete();
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size(input logic bulky);
      int p;
      p = $urandom_range(99);
      if (p < 85)
         return SIZE_W'(bulky ? $urandom_range(MAX_PACKET / 2, MAX_PACKET)
                              : $urandom_range(1, MAX_PACKET));
      if (p < 90)
         return '0;
      if (p < 95)
         return SIZE_W'($urandom_range(MAX_PACKET + 1, (1 << SIZE_W) - 1));
      return SIZE_W'($urandom);
   endfunction

   task automatic run_phase(input traffic_mode_type mode, input int items);
      int                  done;
      int                  p;
      int                  w_acq, w_commit, w_pop, w_release, w_clear;
      logic [CMD_W-1:0]    cmd;
      logic [HANDLE_W-1:0] handle;
      logic                flush;
      done = 0;
      case (mode)
         MODE_FILL:  begin w_acq = 70; w_commit = 15; w_pop = 8;  w_release = 3;  w_clear = 0; end
         MODE_DRAIN: begin w_acq = 15; w_commit = 35; w_pop = 25; w_release = 20; w_clear = 2; end
         default:    begin w_acq = 35; w_commit = 25; w_pop = 18; w_release = 15; w_clear = 3; end
      endcase
      while (done < items) begin
         p      = $urandom_range(99);
         handle = HANDLE_W'($urandom);
         flush  = ($urandom_range(3) == 0);
         if (p < w_acq)
            cmd = CMD_ACQUIRE;
         else if (p < w_acq + w_commit)
            cmd = CMD_COMMIT;
         else if (p < w_acq + w_commit + w_pop)
            cmd = CMD_POP;
         else if (p < w_acq + w_commit + w_pop + w_release)
            cmd = CMD_RELEASE;
         else if (p < w_acq + w_commit + w_pop + w_release + w_clear)
            cmd = CMD_CLEAR;
         else
            cmd = CMD_W'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
         if (cmd == CMD_COMMIT && open_handles.size() != 0 && $urandom_range(9) != 0)
            handle = open_handles.pop_front();
         send_item(cmd, pick_size(mode == MODE_FILL), handle, flush);
         if (int'(cmd) < FIRST_SPARE_CMD)
            done++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_ACQUIRE, 16'd1, '0, 1'b0);
      send_item(CMD_ACQUIRE, SIZE_W'(MAX_PACKET), '0, 1'b0);
      send_item(CMD_ACQUIRE, '0, '0, 1'b0);
      send_item(CMD_ACQUIRE, SIZE_W'(MAX_PACKET + 1), '0, 1'b0);
      send_item(CMD_ACQUIRE, '1, '1, 1'b1);
      send_item(CMD_POP, '0, '0, 1'b0);
      send_item(CMD_COMMIT, '0, '0, 1'b0);
      send_item(CMD_COMMIT, '0, '0, 1'b0);
      send_item(CMD_COMMIT, '0, '0, 1'b0);
      send_item(CMD_POP, '0, '0, 1'b1);
      send_item(CMD_POP, '0, '0, 1'b0);
      send_item(CMD_RELEASE, '0, '0, 1'b0);
      send_item(CMD_RELEASE, '0, '0, 1'b0);
      send_item(CMD_RELEASE, '0, '0, 1'b0);
      send_item(CMD_ACQUIRE, 16'd5, '0, 1'b0);
      send_item(CMD_COMMIT, '1, 4'd1, 1'b1);
      send_item(CMD_W'(LAST_SPARE_CMD), '1, '1, 1'b1);
      send_item(CMD_CLEAR, '0, '0, 1'b0);
      send_item(CMD_POP, '0, '0, 1'b1);
      send_item(CMD_RELEASE, '0, '0, 1'b0);
      send_item(CMD_ACQUIRE, 16'd100, '0, 1'b0);
      send_item(CMD_COMMIT, '0, '1, 1'b0);
      send_item(CMD_W'(FIRST_SPARE_CMD), '0, '0, 1'b0);
      send_item(CMD_W'(FIRST_SPARE_CMD + 1), '1, '1, 1'b0);
      drain_responses();

      run_phase(MODE_FILL, 80);
      run_phase(MODE_DRAIN, 60);
      drain_responses();
      sender_idles = 1'b0;
      run_phase(MODE_MIXED, 100);
      sender_idles = 1'b1;
      run_phase(MODE_FILL, 80);
      drain_responses();
      run_phase(MODE_DRAIN, 80);

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/satq_pkg.sv
hdl/satq_ctrl.sv
hdl/satq_dpath.sv
hdl/segment_accumulating_tx_queue.sv
tb/sv/segment_accumulating_tx_queue_tb.sv
